// ===== sv/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // Request codes carried in the low bits of the input transfer.
    typedef enum logic [1:0] {
        FN_ADD      = 2'd0,
        FN_TICK     = 2'd1,
        FN_DISPATCH = 2'd2,
        FN_QUERY    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWITCH
    } state_t;

    // One row of the task memory.
    typedef struct packed {
        logic [63:0] last_run;
        logic [63:0] runs;
        logic [63:0] switches_in;
        logic [63:0] charged;
        logic [15:0] remaining;
        logic [15:0] slice;
    } task_rec_t;

    // Contents of the idle task's row after reset.
    localparam task_rec_t REC_IDLE_TASK = '{
        last_run:    64'd0,
        runs:        64'd0,
        switches_in: 64'd0,
        charged:     64'd0,
        remaining:   16'd1,
        slice:       16'd1
    };

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_req_t;

    // One result; declared from the highest field down so that the packed
    // value matches the output bus layout with ok in bit zero.
    typedef struct packed {
        logic [63:0] task_last_run;
        logic [63:0] task_runs;
        logic [63:0] task_switches_in;
        logic [63:0] task_charged;
        logic [15:0] task_remaining;
        logic [15:0] task_slice;
        logic [63:0] switch_total;
        logic [63:0] last_tick;
        logic [3:0]  current_task;
        logic [4:0]  num_tasks;
        logic        ok;
    } sched_res_t;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 432;
    localparam int M_PAD_W  = M_DATA_W - $bits(sched_res_t);

endpackage

`default_nettype wire

// ===== sv/rrts_task_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_task_mem #(
    parameter int MAX_TASKS = 16,
    localparam int AW = $clog2(MAX_TASKS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rrts_pkg::mem_req_t req,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire rrts_pkg::task_rec_t wr_data,
    output rrts_pkg::task_rec_t     rd_data
);
    import rrts_pkg::*;

    task_rec_t mem [MAX_TASKS];
    task_rec_t rd_data_reg;
    logic      e0_valid_reg, e0_valid_next;
    logic      dflt_reg, dflt_next;

    // Rows above the idle task are always written by an add before a read of them is used,
    // so only row zero needs a reset value, supplied until its first write.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        e0_valid_next = e0_valid_reg | (req.wr_en && (wr_addr == '0));
        dflt_next     = req.rd_en ? ((rd_addr == '0) && !e0_valid_reg) : dflt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg <= 1'b0;
            dflt_reg     <= 1'b0;
        end
        else
        begin
            e0_valid_reg <= e0_valid_next;
            dflt_reg     <= dflt_next;
        end
    end

    assign rd_data = dflt_reg ? REC_IDLE_TASK : rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rrts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl #(
    parameter int MAX_TASKS = 16,
    localparam int AW = $clog2(MAX_TASKS),
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rrts_pkg::func_t    func,
    input  wire logic [15:0]        slice_ticks,
    input  wire logic [63:0]        tick_value,
    input  wire logic [3:0]         task_index,
    input  wire logic               out_free,
    output logic                    res_load,
    output rrts_pkg::sched_res_t    res,
    output rrts_pkg::mem_req_t      mem_req,
    output logic [AW-1:0]           rd_addr,
    output logic [AW-1:0]           wr_addr,
    output rrts_pkg::task_rec_t     wr_data,
    input  wire rrts_pkg::task_rec_t rd_data
);
    import rrts_pkg::*;

    localparam int XW = (AW > 4) ? AW : 4;
    localparam int KW = (CW > 4) ? CW : 4;
    localparam int TW = (CW > 5) ? CW : 5;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] current_reg, current_next;
    logic [63:0]   last_tick_reg, last_tick_next;
    logic [63:0]   switch_total_reg, switch_total_next;

    func_t         func_reg;
    logic [15:0]   slice_reg;
    logic [63:0]   tick_reg;
    logic          qok_reg;

    logic [XW-1:0] idx_x;
    logic [XW-1:0] cur_x;
    logic [TW-1:0] count_x;
    logic          idx_in_range;
    logic          cur_valid;
    logic          full;
    logic [CW-1:0] nxt_wide;
    logic [AW-1:0] nxt;
    logic [15:0]   rem_dec;
    logic          expire;
    logic          do_switch;
    logic [15:0]   add_slice;

    assign idx_x        = XW'(task_index);
    assign idx_in_range = KW'(task_index) < KW'(count_reg);
    assign cur_valid    = CW'(current_reg) < count_reg;
    assign full         = count_reg == CW'(MAX_TASKS);
    assign nxt_wide     = CW'(current_reg) + CW'(1);
    assign nxt          = (nxt_wide == count_reg) ? '0 : nxt_wide[AW-1:0];
    assign rem_dec      = rd_data.remaining - ((rd_data.remaining != 16'd0) ? 16'd1 : 16'd0);
    assign expire       = rem_dec == 16'd0;
    assign do_switch    = (state_reg == ST_EXEC) && (func_reg == FN_TICK) && cur_valid
                          && expire && (nxt != current_reg);
    assign add_slice    = (slice_reg == 16'd0) ? 16'd1 : slice_reg;
    assign count_x      = TW'(count_next);
    assign cur_x        = XW'(current_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = do_switch ? ST_SWITCH : ST_IDLE;
                end
            end
            ST_SWITCH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = state_reg == ST_IDLE;
        mem_req           = '0;
        rd_addr           = current_reg;
        wr_addr           = current_reg;
        wr_data           = rd_data;
        count_next        = count_reg;
        current_next      = current_reg;
        last_tick_next    = last_tick_reg;
        switch_total_next = switch_total_reg;
        res_load          = 1'b0;
        res               = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_req.rd_en = 1'b1;
                    rd_addr       = (func == FN_QUERY) ? idx_x[AW-1:0] : current_reg;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    res_load = !do_switch;
                    case (func_reg)
                        FN_ADD:
                        begin
                            if (!full)
                            begin
                                mem_req.wr_en = 1'b1;
                                wr_addr       = count_reg[AW-1:0];
                                wr_data       = '{
                                    last_run:    64'd0,
                                    runs:        64'd0,
                                    switches_in: 64'd0,
                                    charged:     64'd0,
                                    remaining:   add_slice,
                                    slice:       add_slice
                                };
                                count_next    = count_reg + CW'(1);
                                res.ok        = 1'b1;
                            end
                        end
                        FN_TICK:
                        begin
                            last_tick_next = tick_reg;
                            if (cur_valid)
                            begin
                                mem_req.wr_en     = 1'b1;
                                wr_data.charged   = rd_data.charged + 64'd1;
                                wr_data.remaining = expire ? rd_data.slice : rem_dec;
                            end
                            if (do_switch)
                            begin
                                current_next      = nxt;
                                switch_total_next = switch_total_reg + 64'd1;
                                mem_req.rd_en     = 1'b1;
                                rd_addr           = nxt;
                            end
                        end
                        FN_DISPATCH:
                        begin
                            if (cur_valid)
                            begin
                                mem_req.wr_en    = 1'b1;
                                wr_data.runs     = rd_data.runs + 64'd1;
                                wr_data.last_run = tick_reg;
                                res.ok           = 1'b1;
                            end
                        end
                        FN_QUERY:
                        begin
                            if (qok_reg)
                            begin
                                res.ok               = 1'b1;
                                res.task_slice       = rd_data.slice;
                                res.task_remaining   = rd_data.remaining;
                                res.task_charged     = rd_data.charged;
                                res.task_switches_in = rd_data.switches_in;
                                res.task_runs        = rd_data.runs;
                                res.task_last_run    = rd_data.last_run;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWITCH:
            begin
                // The row of the task just switched to is being read back here.
                if (out_free)
                begin
                    res_load            = 1'b1;
                    mem_req.wr_en       = 1'b1;
                    wr_data.switches_in = rd_data.switches_in + 64'd1;
                    wr_data.remaining   = rd_data.slice;
                end
            end
            default:
            begin
            end
        endcase

        res.num_tasks    = count_x[4:0];
        res.current_task = cur_x[3:0];
        res.last_tick    = last_tick_next;
        res.switch_total = switch_total_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            slice_reg <= slice_ticks;
            tick_reg  <= tick_value;
            qok_reg   <= idx_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= CW'(1);
            current_reg      <= '0;
            last_tick_reg    <= '0;
            switch_total_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            current_reg      <= current_next;
            last_tick_reg    <= last_tick_next;
            switch_total_reg <= switch_total_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/round_robin_time_slice_scheduler.sv =====
// Each item reads the task memory when its input transfer is taken; once the result slot
// is free, the row is written back and the result registered, except that a switching
// tick updates the new task's row before its result. Items are worked one at a time.
// Reset is asynchronous and active low; the table then holds the idle task with a
// one-tick slice, running, with no clearing pass, so items are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_time_slice_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // From bit 0: func[1:0], slice_ticks[15:0], tick_value[63:0], task_index[3:0],
    // then two zero bits.
    input  wire logic [rrts_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // From bit 0: ok, num_tasks[4:0], current_task[3:0], last_tick[63:0],
    // switch_total[63:0], task_slice[15:0], task_remaining[15:0], task_charged[63:0],
    // task_switches_in[63:0], task_runs[63:0], task_last_run[63:0], then six zero bits.
    output logic [rrts_pkg::M_DATA_W-1:0]          m_tdata
);
    import rrts_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);

    // Fields of the incoming transfer.
    func_t       in_func;
    logic [15:0] in_slice;
    logic [63:0] in_tick;
    logic [3:0]  in_index;

    // Handshake between the controller and the output register.
    logic        out_free;
    logic        res_load;
    sched_res_t  res;

    // Task memory port.
    mem_req_t    mem_req;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    task_rec_t   wr_data;
    task_rec_t   rd_data;

    // The output register holds a finished result while the controller is free
    // to accept and start the next item.
    logic        out_valid_reg, out_valid_next;
    sched_res_t  out_reg;

    assign in_func  = func_t'(s_tdata[1:0]);
    assign in_slice = s_tdata[17:2];
    assign in_tick  = s_tdata[81:18];
    assign in_index = s_tdata[85:82];

    // The result slot can take a new result when it is empty or is being drained
    // by a transfer in this very cycle.
    assign out_free = !out_valid_reg || m_tready;

    rrts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (in_func),
        .slice_ticks (in_slice),
        .tick_value  (in_tick),
        .task_index  (in_index),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_req     (mem_req),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_data     (rd_data)
    );

    rrts_task_mem #(
        .MAX_TASKS (MAX_TASKS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg};

endmodule

`default_nettype wire

// ===== sv/rrts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [rrts_pkg::S_DATA_W-1:0]  s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rrts_pkg::M_DATA_W-1:0]  m_tdata
);
    import rrts_pkg::*;

    // A result held back by the consumer stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Items are worked one at a time: after a transfer in, the input side closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A new result only appears at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in flight");

    // A result that is not ok never carries per-task counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[425:138] == '0)
        else $error("per-task fields set on a result that is not ok");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire
